FILE: design/sha256_stream_hash_assert.svh
// Assertion macros for the top level of the SHA-256 stream hash.
`ifndef SHA256_STREAM_HASH_ASSERT_SVH
`define SHA256_STREAM_HASH_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SHS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SHS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/shs_pkg.sv
// Package of the SHA-256 stream hash: constants, round functions and control types.
package shs_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWord = 8;
  localparam int unsigned NumRnd  = 64;
  localparam int unsigned BlkBits = 512;

  localparam logic [7:0] PadMarker = 8'h80;

  // Controls from the sequencer to the round core.
  typedef struct packed {
    logic init;   // load the initial hash values into the chain
    logic load;   // copy the chain into the working variables
    logic round;  // run one compression round
    logic fold;   // add the working variables into the chain
  } shs_core_ctl_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    case (idx)
      3'd0:    init_hash = 32'h6a09e667;
      3'd1:    init_hash = 32'hbb67ae85;
      3'd2:    init_hash = 32'h3c6ef372;
      3'd3:    init_hash = 32'ha54ff53a;
      3'd4:    init_hash = 32'h510e527f;
      3'd5:    init_hash = 32'h9b05688c;
      3'd6:    init_hash = 32'h1f83d9ab;
      default: init_hash = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

FILE: design/shs_msg_sched.sv
// Block buffer and message schedule: bytes shift in, schedule words shift out.
module shs_msg_sched
  import shs_pkg::*;
(
  input  logic              clk,
  input  logic              byte_shift,
  input  logic [7:0]        byte_in,
  input  logic              word_shift,
  output logic [WordW-1:0]  w_cur
);

  logic [BlkBits-1:0] blk_r;
  logic [BlkBits-1:0] blk_nxt;
  logic [WordW-1:0]   w_new;

  // Word j of the window sits at the top end for j = 0, so word 0 is the oldest.
  assign w_cur = blk_r[BlkBits-1 -: WordW];

  assign w_new = blk_r[BlkBits-1 -: WordW]
               + small_sig0(blk_r[BlkBits-1-WordW -: WordW])
               + blk_r[BlkBits-1-9*WordW -: WordW]
               + small_sig1(blk_r[BlkBits-1-14*WordW -: WordW]);

  always_comb begin
    blk_nxt = blk_r;
    if (byte_shift) begin
      blk_nxt = {blk_r[BlkBits-9:0], byte_in};
    end else if (word_shift) begin
      blk_nxt = {blk_r[BlkBits-1-WordW:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt;
  end

endmodule

FILE: design/shs_round_core.sv
// Compression round unit with its working variables and the chaining value.
module shs_round_core
  import shs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  shs_core_ctl_t     ctl,
  input  logic [WordW-1:0]  k_in,
  input  logic [WordW-1:0]  w_in,
  input  logic [2:0]        rd_idx,
  output logic [WordW-1:0]  rd_word
);

  logic [WordW-1:0] chain_r [NumWord];
  logic [WordW-1:0] chain_nxt [NumWord];
  logic [WordW-1:0] v_r [NumWord];
  logic [WordW-1:0] v_nxt [NumWord];
  logic [WordW-1:0] t1;
  logic [WordW-1:0] t2;

  assign t1 = v_r[7] + big_sig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + k_in + w_in;
  assign t2 = big_sig0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  assign rd_word = chain_r[rd_idx];

  always_comb begin
    v_nxt     = v_r;
    chain_nxt = chain_r;
    if (ctl.load) begin
      v_nxt = chain_r;
    end else if (ctl.round) begin
      v_nxt[7] = v_r[6];
      v_nxt[6] = v_r[5];
      v_nxt[5] = v_r[4];
      v_nxt[4] = v_r[3] + t1;
      v_nxt[3] = v_r[2];
      v_nxt[2] = v_r[1];
      v_nxt[1] = v_r[0];
      v_nxt[0] = t1 + t2;
    end
    for (int i = 0; i < NumWord; i++) begin
      if (ctl.init) begin
        chain_nxt[i] = init_hash(3'(i));
      end else if (ctl.fold) begin
        chain_nxt[i] = chain_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumWord; i++) begin
        chain_r[i] <= init_hash(3'(i));
      end
    end else begin
      chain_r <= chain_nxt;
    end
  end

endmodule

FILE: design/sha256_stream_hash.sv
// SHA-256 stream hash top level: byte intake, padding sequencer and digest output.
//
// Hashes a byte stream with SHA-256 and returns the digest as eight 32-bit items,
// most significant word first. An input item carrying a byte is taken while in_ready
// is high; the item that fills a 64-byte block then keeps in_ready low while the
// single round unit runs the 64 rounds and then folds the result into the chaining
// value. An end-of-message item starts padding, which writes one byte a cycle into
// the block up to its end, so closing a message costs padding up to the end of the
// block and a compression, twice over when the length field does not fit in the
// current block. The eight digest items then follow, one per cycle as out_ready
// allows, and the block is ready for the next message once the last of them has
// been taken.
`include "sha256_stream_hash_assert.svh"

module sha256_stream_hash
  import shs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_msg_byte,
  input  logic              in_byte_valid,
  input  logic              in_end_of_message,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WordW-1:0]  out_digest_word,
  output logic [2:0]        out_word_index,
  output logic              out_last_word
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        fin_r, fin_nxt;     // message is being closed
  logic        mark_r, mark_nxt;   // padding marker already written
  logic        extra_r, extra_nxt; // length goes into a further block

  logic          in_acc;
  logic          out_acc;
  logic          byte_shift;
  logic [7:0]    byte_in;
  logic [7:0]    len_byte;
  logic [WordW-1:0] w_cur;
  shs_core_ctl_t ctl;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign in_acc          = in_valid && in_ready;
  assign out_acc         = out_valid && out_ready;
  assign out_word_index  = idx_r;
  assign out_last_word   = &idx_r;

  // Length bytes go out big-endian: position 56 carries bits 63..56.
  assign len_byte = 8'(bits_r >> {~fill_r[2:0], 3'b000});

  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    bits_nxt   = bits_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    fin_nxt    = fin_r;
    mark_nxt   = mark_r;
    extra_nxt  = extra_r;
    byte_shift = 1'b0;
    byte_in    = in_msg_byte;
    ctl        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_byte_valid) begin
            byte_shift = 1'b1;
            fill_nxt   = fill_r + 6'd1;
            bits_nxt   = bits_r + 64'd8;
          end
          if (in_byte_valid && (&fill_r)) begin
            state_nxt = ST_COMP;
            rnd_nxt   = '0;
            ctl.load  = 1'b1;
            fin_nxt   = in_end_of_message;
          end else if (in_end_of_message) begin
            state_nxt = ST_PAD;
            fin_nxt   = 1'b1;
          end
        end
      end
      ST_PAD: begin
        byte_shift = 1'b1;
        fill_nxt   = fill_r + 6'd1;
        if (!mark_r) begin
          byte_in   = PadMarker;
          mark_nxt  = 1'b1;
          extra_nxt = (fill_r[5:3] == 3'b111);
        end else if (extra_r || (fill_r[5:3] != 3'b111)) begin
          byte_in = 8'h00;
        end else begin
          byte_in = len_byte;
        end
        if (&fill_r) begin
          state_nxt = ST_COMP;
          rnd_nxt   = '0;
          ctl.load  = 1'b1;
        end
      end
      ST_COMP: begin
        ctl.round = 1'b1;
        rnd_nxt   = rnd_r + 6'd1;
        if (&rnd_r) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        ctl.fold = 1'b1;
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (mark_r && !extra_r) begin
          state_nxt = ST_OUT;
          idx_nxt   = '0;
        end else begin
          state_nxt = ST_PAD;
          extra_nxt = 1'b0;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (&idx_r) begin
            state_nxt = ST_IDLE;
            ctl.init  = 1'b1;
            bits_nxt  = '0;
            fill_nxt  = '0;
            fin_nxt   = 1'b0;
            mark_nxt  = 1'b0;
            extra_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      bits_r  <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      mark_r  <= 1'b0;
      extra_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      rnd_r   <= rnd_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      mark_r  <= mark_nxt;
      extra_r <= extra_nxt;
    end
  end

  shs_msg_sched u_sched (
    .clk        (clk),
    .byte_shift (byte_shift),
    .byte_in    (byte_in),
    .word_shift (ctl.round),
    .w_cur      (w_cur)
  );

  shs_round_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .k_in    (round_k(rnd_r)),
    .w_in    (w_cur),
    .rd_idx  (idx_r),
    .rd_word (out_digest_word)
  );

  `SHS_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "input taken while digest is pending")
  `SHS_ASSERT_NOW(a_block_aligned, state_r == ST_COMP, fill_r == 6'd0, "compression on a partial block")
  `SHS_ASSERT_NEXT(a_round_end, state_r == ST_COMP && (&rnd_r), state_r == ST_FOLD, "round count lost")
  `SHS_ASSERT_NEXT(a_restart, out_acc && out_last_word, state_r == ST_IDLE && bits_r == 64'd0 && !fin_r, "message state not cleared after digest")

endmodule
